[rtl/scil_pkg.sv]
// shared constants, codes and types of the sorted cost insert list
// depends on nothing; imported by every other file of the block
`default_nettype none

package scil_pkg;

    localparam int CAPACITY  = 64;
    localparam int TAG_BITS  = 16;
    localparam int COST_BITS = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int POS_W     = $clog2(CAPACITY + 1);
    localparam int CFG_W     = 7;
    localparam int OP_W      = 2;
    localparam int RANK_W    = 6;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DISPATCH = 6'b000010,
        ST_WALK     = 6'b000100,
        ST_PLACE    = 6'b001000,
        ST_READ     = 6'b010000,
        ST_DONE     = 6'b100000
    } state_t;

    typedef struct packed {
        logic [COST_BITS-1:0] cost;
        logic [TAG_BITS-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic walk_start;
        logic place_first;
        logic step;
        logic place;
        logic read_issue;
        logic read_take;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            count_zero;
        logic            ge;
        logic            idx_zero;
        logic            out_free;
    } status_t;

endpackage

`default_nettype wire

[rtl/scil_in_if.sv]
// input channel of the sorted cost insert list: valid, ready and one item
// depends on scil_pkg
`default_nettype none

interface scil_in_if import scil_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [COST_BITS-1:0] new_cost;
    logic [TAG_BITS-1:0]  new_tag;
    logic [RANK_W-1:0]    read_rank;

    modport source (output valid, op, new_cost, new_tag, read_rank, input ready);
    modport sink   (input valid, op, new_cost, new_tag, read_rank, output ready);
endinterface

`default_nettype wire

[rtl/scil_out_if.sv]
// output channel of the sorted cost insert list: valid, ready and one result item
// depends on scil_pkg
`default_nettype none

interface scil_out_if import scil_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [COST_BITS-1:0] out_cost;
    logic [TAG_BITS-1:0]  out_tag;
    logic [POS_W-1:0]     insert_pos;
    logic [POS_W-1:0]     entry_count;
    logic                 dropped;
    logic                 rank_valid;

    modport source (output valid, out_cost, out_tag, insert_pos, entry_count, dropped,
                    rank_valid, input ready);
    modport sink   (input valid, out_cost, out_tag, insert_pos, entry_count, dropped,
                    rank_valid, output ready);
endinterface

`default_nettype wire

[rtl/sorted_cost_insert_list_unit.sv]
// top level of the sorted cost insert list: controller plus datapath
// depends on scil_pkg, scil_in_if, scil_out_if, scil_ctrl, scil_dpath
//
//  port       dir   kind          carries
//  in_ch      in    valid/ready   op, new_cost, new_tag, read_rank
//  out_ch     out   valid/ready   out_cost, out_tag, insert_pos, entry_count,
//                                 dropped, rank_valid
//  cfg_*      in    write only    capacity_in_use
//
// one item at a time; an insert walks the stored entries down from the top,
// one memory read per entry walked
// a clear or unused op goes straight from dispatch to done, a read through the read state
// a finished result sits in the output register while the next item is taken
// rst_n is asynchronous; the entry memory needs no clearing pass
`default_nettype none

module sorted_cost_insert_list_unit import scil_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    scil_in_if.sink               in_ch,
    scil_out_if.source            out_ch,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    cmd_t    cmd;
    status_t st;
    logic    in_ready;

    scil_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    scil_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_op          (in_ch.op),
        .in_cost        (in_ch.new_cost),
        .in_tag         (in_ch.new_tag),
        .in_rank        (in_ch.read_rank),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_cost       (out_ch.out_cost),
        .out_tag        (out_ch.out_tag),
        .out_pos        (out_ch.insert_pos),
        .out_count      (out_ch.entry_count),
        .out_drop       (out_ch.dropped),
        .out_rank_valid (out_ch.rank_valid)
    );

    assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

[rtl/scil_ctrl.sv]
// controller of the sorted cost insert list: sequences clear, insert walk and read
// depends on scil_pkg; drives scil_dpath through cmd_t and watches status_t
`default_nettype none

module scil_ctrl import scil_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t st,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (st.op)
                    OP_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_DONE;
                    end
                    OP_INSERT:
                    begin
                        if (st.count_zero)
                        begin
                            cmd.place_first = 1'b1;
                        end
                        else
                        begin
                            cmd.walk_start = 1'b1;
                        end
                        state_next = st.count_zero ? ST_PLACE : ST_WALK;
                    end
                    OP_READ:
                    begin
                        cmd.read_issue = 1'b1;
                        state_next     = ST_READ;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (!st.ge || st.idx_zero)
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = ST_DONE;
            end
            ST_READ:
            begin
                cmd.read_take = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/scil_dpath.sv]
// datapath of the sorted cost insert list: entry memory, walk index, count,
// capacity register, result and output registers; depends on scil_pkg
`default_nettype none

module scil_dpath import scil_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cmd_t                 cmd,
    output status_t                   st,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic [OP_W-1:0]      in_op,
    input  wire logic [COST_BITS-1:0] in_cost,
    input  wire logic [TAG_BITS-1:0]  in_tag,
    input  wire logic [RANK_W-1:0]    in_rank,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [COST_BITS-1:0]      out_cost,
    output logic [TAG_BITS-1:0]       out_tag,
    output logic [POS_W-1:0]          out_pos,
    output logic [POS_W-1:0]          out_count,
    output logic                      out_drop,
    output logic                      out_rank_valid
);

    entry_t mem [CAPACITY];

    logic [CFG_W-1:0]     cfg_reg;
    logic [POS_W-1:0]     count_reg;
    logic                 out_valid_reg;
    logic [OP_W-1:0]      op_reg;
    logic [COST_BITS-1:0] cost_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic [RANK_W-1:0]    rank_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [POS_W-1:0]     pos_reg;
    entry_t               rd_reg;
    logic [COST_BITS-1:0] res_cost_reg;
    logic [TAG_BITS-1:0]  res_tag_reg;
    logic [POS_W-1:0]     res_pos_reg;
    logic                 res_drop_reg;
    logic                 res_valid_reg;
    logic [COST_BITS-1:0] out_cost_reg;
    logic [TAG_BITS-1:0]  out_tag_reg;
    logic [POS_W-1:0]     out_pos_reg;
    logic [POS_W-1:0]     out_count_reg;
    logic                 out_drop_reg;
    logic                 out_rank_valid_reg;

    logic [POS_W-1:0]     cap_live;
    logic                 full;
    logic                 ge;
    logic                 idx_zero;
    logic                 at_top;
    logic                 rank_ok;
    logic [POS_W-1:0]     idx_up;
    logic                 mem_we;
    logic [IDX_W-1:0]     waddr;
    entry_t               wdata;
    logic                 rd_en;
    logic [IDX_W-1:0]     raddr;

    // capacity register clamped to 1..CAPACITY
    always_comb
    begin
        priority if (cfg_reg == '0)
        begin
            cap_live = POS_W'(1);
        end
        else if (POS_W'(cfg_reg) > POS_W'(CAPACITY))
        begin
            cap_live = POS_W'(CAPACITY);
        end
        else
        begin
            cap_live = POS_W'(cfg_reg);
        end
    end

    assign full     = (count_reg == cap_live);
    assign ge       = (rd_reg.cost >= cost_reg);
    assign idx_zero = (idx_reg == '0);
    assign idx_up   = POS_W'(idx_reg) + POS_W'(1);
    assign at_top   = (idx_up == cap_live);
    assign rank_ok  = (POS_W'(rank_reg) < count_reg);

    assign st.op         = op_reg;
    assign st.count_zero = (count_reg == '0);
    assign st.ge         = ge;
    assign st.idx_zero   = idx_zero;
    assign st.out_free   = !out_valid_reg || out_ready;

    // memory port control
    always_comb
    begin
        mem_we = 1'b0;
        waddr  = idx_up[IDX_W-1:0];
        wdata  = rd_reg;
        rd_en  = 1'b0;
        raddr  = idx_reg - IDX_W'(1);
        if (cmd.walk_start)
        begin
            rd_en = 1'b1;
            raddr = IDX_W'(count_reg - POS_W'(1));
        end
        if (cmd.step && ge)
        begin
            mem_we = !at_top;
            rd_en  = !idx_zero;
        end
        if (cmd.place)
        begin
            mem_we = (pos_reg != cap_live);
            waddr  = pos_reg[IDX_W-1:0];
            wdata  = '{cost: cost_reg, tag: tag_reg};
        end
        if (cmd.read_issue)
        begin
            rd_en = 1'b1;
            raddr = IDX_W'(rank_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_W'(CAPACITY);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (cmd.load && (count_reg > cap_live))
            begin
                count_reg <= cap_live;
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            if (cmd.place && !full)
            begin
                count_reg <= count_reg + POS_W'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= in_op;
            cost_reg      <= in_cost;
            tag_reg       <= in_tag;
            rank_reg      <= in_rank;
            res_cost_reg  <= '0;
            res_tag_reg   <= '0;
            res_pos_reg   <= '0;
            res_drop_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        if (cmd.walk_start)
        begin
            idx_reg <= IDX_W'(count_reg - POS_W'(1));
        end
        if (cmd.place_first)
        begin
            pos_reg <= '0;
        end
        if (cmd.step)
        begin
            if (ge)
            begin
                // top entry of a full list falls off
                if (at_top)
                begin
                    res_cost_reg <= rd_reg.cost;
                    res_tag_reg  <= rd_reg.tag;
                end
                if (idx_zero)
                begin
                    pos_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg - IDX_W'(1);
                end
            end
            else
            begin
                pos_reg <= idx_up;
            end
        end
        if (cmd.place)
        begin
            if (pos_reg == cap_live)
            begin
                res_cost_reg <= cost_reg;
                res_tag_reg  <= tag_reg;
                res_pos_reg  <= POS_W'(CAPACITY);
                res_drop_reg <= 1'b1;
            end
            else
            begin
                res_pos_reg  <= pos_reg;
                res_drop_reg <= full;
            end
        end
        if (cmd.read_take && rank_ok)
        begin
            res_valid_reg <= 1'b1;
            res_cost_reg  <= rd_reg.cost;
            res_tag_reg   <= rd_reg.tag;
        end
        if (cmd.emit)
        begin
            out_cost_reg       <= res_cost_reg;
            out_tag_reg        <= res_tag_reg;
            out_pos_reg        <= res_pos_reg;
            out_count_reg      <= count_reg;
            out_drop_reg       <= res_drop_reg;
            out_rank_valid_reg <= res_valid_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_cost       = out_cost_reg;
    assign out_tag        = out_tag_reg;
    assign out_pos        = out_pos_reg;
    assign out_count      = out_count_reg;
    assign out_drop       = out_drop_reg;
    assign out_rank_valid = out_rank_valid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= POS_W'(CAPACITY))
        else $error("entry count above capacity");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (POS_W'(waddr) < cap_live))
        else $error("memory write beyond live capacity");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.place && !full) |=> (count_reg == $past(count_reg) + POS_W'(1)))
        else $error("insert into non-full list did not grow count");

    a_drop_not_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_drop_reg && out_rank_valid_reg))
        else $error("drop and rank valid in one result");

    a_pos_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_pos_reg == POS_W'(CAPACITY))) |-> out_drop_reg)
        else $error("new entry dropped without drop flag");

endmodule

`default_nettype wire

[bench/tb.sv]
// testbench of sorted_cost_insert_list_unit: random and directed list operations
// with a scoreboard class that predicts each result item
// depends on scil_pkg, scil_in_if, scil_out_if and the block itself
`timescale 1ns / 1ps

module tb;
    import scil_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [COST_BITS-1:0] cost;
        logic [TAG_BITS-1:0]  tag;
        logic [POS_W-1:0]     pos;
        logic [POS_W-1:0]     count;
        logic                 dropped;
        logic                 rank_valid;
    } list_result_t;

    class list_scoreboard;
        logic [COST_BITS-1:0] costs [CAPACITY];
        logic [TAG_BITS-1:0]  tags [CAPACITY];
        int                   count;
        int                   capacity;
        list_result_t         pending_q [$];
        int                   errors;
        int                   n_clear;
        int                   n_insert;
        int                   n_drop;
        int                   n_read;
        int                   n_read_hit;
        int                   n_unused;
        int                   n_checked;

        function new();
            count      = 0;
            capacity   = CAPACITY;
            errors     = 0;
            n_clear    = 0;
            n_insert   = 0;
            n_drop     = 0;
            n_read     = 0;
            n_read_hit = 0;
            n_unused   = 0;
            n_checked  = 0;
        endfunction

        function void note_input(logic [OP_W-1:0] op, logic [COST_BITS-1:0] cost,
                                 logic [TAG_BITS-1:0] tag, logic [RANK_W-1:0] rank);
            list_result_t r;
            int           cap;
            int           pos;
            int           i;
            r   = '0;
            cap = (capacity < 1) ? 1 : ((capacity > CAPACITY) ? CAPACITY : capacity);
            if (count > cap)
                count = cap;
            case (op)
                OP_CLEAR:
                begin
                    count = 0;
                    n_clear++;
                end
                OP_INSERT:
                begin
                    n_insert++;
                    pos = 0;
                    while (pos < count && costs[pos] < cost)
                        pos++;
                    if (count >= cap)
                    begin
                        n_drop++;
                        r.dropped = 1'b1;
                        if (pos >= cap)
                        begin
                            r.cost = cost;
                            r.tag  = tag;
                            r.pos  = POS_W'(CAPACITY);
                        end
                        else
                        begin
                            r.cost = costs[cap-1];
                            r.tag  = tags[cap-1];
                            for (i = cap - 1; i > pos; i--)
                            begin
                                costs[i] = costs[i-1];
                                tags[i]  = tags[i-1];
                            end
                            costs[pos] = cost;
                            tags[pos]  = tag;
                            r.pos      = POS_W'(pos);
                        end
                    end
                    else
                    begin
                        for (i = count; i > pos; i--)
                        begin
                            costs[i] = costs[i-1];
                            tags[i]  = tags[i-1];
                        end
                        costs[pos] = cost;
                        tags[pos]  = tag;
                        count++;
                        r.pos = POS_W'(pos);
                    end
                end
                OP_READ:
                begin
                    n_read++;
                    if (int'(rank) < count)
                    begin
                        n_read_hit++;
                        r.rank_valid = 1'b1;
                        r.cost       = costs[rank];
                        r.tag        = tags[rank];
                    end
                end
                default:
                    n_unused++;
            endcase
            r.count = POS_W'(count);
            pending_q.insert(pending_q.size(), r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            if (pending_q.size() == 0)
            begin
                $error("result item with nothing expected: cost %0h tag %0h", got.cost, got.tag);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            compare_field("out_cost", 32'(want.cost), 32'(got.cost));
            compare_field("out_tag", 32'(want.tag), 32'(got.tag));
            compare_field("insert_pos", 32'(want.pos), 32'(got.pos));
            compare_field("entry_count", 32'(want.count), 32'(got.count));
            compare_field("dropped", 32'(want.dropped), 32'(got.dropped));
            compare_field("rank_valid", 32'(want.rank_valid), 32'(got.rank_valid));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 calm;
    int                   n_cfg;
    list_scoreboard       sb;

    scil_in_if  in_ch ();
    scil_out_if out_ch ();

    sorted_cost_insert_list_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_input(in_ch.op, in_ch.new_cost, in_ch.new_tag, in_ch.read_rank);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result({out_ch.out_cost, out_ch.out_tag, out_ch.insert_pos,
                             out_ch.entry_count, out_ch.dropped, out_ch.rank_valid});
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= calm || ($urandom_range(99) >= 20);
        end
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [COST_BITS-1:0] cost,
                             input logic [TAG_BITS-1:0] tag, input logic [RANK_W-1:0] rank);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 20)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.new_cost  <= cost;
        in_ch.new_tag   <= tag;
        in_ch.read_rank <= rank;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CFG_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we      <= 1'b0;
        sb.capacity = int'(value);
        n_cfg++;
    endtask

    function automatic logic [COST_BITS-1:0] pick_cost();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return COST_BITS'($urandom_range(15));
        else if (sel < 70)
            return COST_BITS'($urandom_range(1000));
        else if (sel < 90)
            return COST_BITS'($urandom());
        else if (sel < 95)
            return '1;
        else
            return '0;
    endfunction

    task automatic random_item(input int clear_permille);
        logic [OP_W-1:0]   op;
        logic [RANK_W-1:0] rank;
        int unsigned       sel;
        sel = $urandom_range(999);
        if (sel < clear_permille)
            op = OP_CLEAR;
        else if (sel < clear_permille + 20)
            op = OP_UNUSED;
        else if (sel < 620)
            op = OP_INSERT;
        else
            op = OP_READ;
        if (sb.count > 0 && $urandom_range(99) < 75)
            rank = RANK_W'($urandom_range(sb.count - 1));
        else
            rank = RANK_W'($urandom_range(63));
        send_item(op, pick_cost(), TAG_BITS'($urandom_range(16'hFFFF)), rank);
    endtask

    initial
    begin
        int caps [11]  = '{64, 127, 33, 2, 1, 0, 5, 64, 65, 3, 16};
        int items [11] = '{150, 120, 80, 60, 60, 60, 60, 150, 60, 50, 65};
        int p;
        int k;

        sb              = new();
        n_cfg           = 0;
        calm            = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.op        = OP_CLEAR;
        in_ch.new_cost  = '0;
        in_ch.new_tag   = '0;
        in_ch.read_rank = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list, unused op, equal keys, extreme costs and ranks
        send_item(OP_READ, '0, '0, 6'd0);
        send_item(OP_UNUSED, '1, '1, '1);
        send_item(OP_INSERT, 32'd100, 16'd1, '0);
        send_item(OP_INSERT, 32'd100, 16'd2, '0);
        send_item(OP_INSERT, '0, '0, '0);
        send_item(OP_INSERT, '1, '1, '0);
        send_item(OP_INSERT, 32'd50, 16'd3, '0);
        send_item(OP_READ, '0, '0, 6'd0);
        send_item(OP_READ, '0, '0, 6'd4);
        send_item(OP_READ, '0, '0, 6'd5);
        send_item(OP_READ, '0, '0, 6'd63);
        send_item(OP_UNUSED, '0, '0, '0);

        // capacity lowered under the count, then drops of new and last entries
        set_capacity(7'd2);
        send_item(OP_READ, '0, '0, 6'd1);
        send_item(OP_READ, '0, '0, 6'd2);
        send_item(OP_INSERT, 32'd200, 16'd4, '0);
        send_item(OP_INSERT, 32'd1, 16'd5, '0);
        send_item(OP_CLEAR, '1, '1, '1);

        // zero capacity acts as one entry
        set_capacity(7'd0);
        send_item(OP_INSERT, 32'd7, 16'd10, '0);
        send_item(OP_INSERT, 32'd7, 16'd6, '0);
        send_item(OP_INSERT, 32'd8, 16'd11, '0);

        // capacity above the array size acts as the full array
        set_capacity(7'd127);
        send_item(OP_INSERT, 32'd3, 16'hFFFF, '0);
        send_item(OP_READ, '0, '0, 6'd1);
        send_item(OP_READ, '0, '0, 6'd0);
        send_item(OP_CLEAR, '0, '0, '0);

        for (p = 0; p < 11; p++)
        begin
            set_capacity(CFG_W'(caps[p]));
            calm = (p == 1);
            for (k = 0; k < items[p]; k++)
            begin
                if (p == 0 && k == 75)
                    wait_drained();
                random_item(caps[p] >= 33 ? 3 : 30);
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        $display("covered %0d clears, %0d inserts (%0d dropped an entry), %0d unused ops",
                 sb.n_clear, sb.n_insert, sb.n_drop, sb.n_unused);
        $display("and %0d reads (%0d in range) over %0d capacity settings; %0d results checked",
                 sb.n_read, sb.n_read_hit, n_cfg, sb.n_checked);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/scil_pkg.sv
rtl/scil_in_if.sv
rtl/scil_out_if.sv
rtl/scil_ctrl.sv
rtl/scil_dpath.sv
rtl/sorted_cost_insert_list_unit.sv
bench/tb.sv
